// ----- design/phlr_pkg.sv -----
`timescale 1ns / 1ps

package phlr_pkg;

    // fixed-point format: unsigned, 2 integer bits and FRAC_BITS fraction bits, range below 4.0
    localparam int FRAC_BITS = 16;
    localparam int VW        = FRAC_BITS + 2;

    typedef logic [VW-1:0]   fx_t;
    typedef fx_t [15:0]      fx_tab_t;

    localparam fx_t ONE   = fx_t'(64'd1 << FRAC_BITS);
    localparam fx_t HALF  = fx_t'(64'd1 << (FRAC_BITS - 1));
    localparam fx_t THIRD = fx_t'((64'd1 << FRAC_BITS) / 3);
    localparam fx_t SIXTH = fx_t'((64'd1 << FRAC_BITS) / 6);
    localparam fx_t TWO3  = fx_t'((64'd2 << FRAC_BITS) / 3);

    // x * 2^F / 255 split as x*A + (x*B)/255
    localparam int DIV_A = (1 << FRAC_BITS) / 255;
    localparam int DIV_B = (1 << FRAC_BITS) % 255;

    // hue segment kind for one channel
    typedef enum logic [1:0] {
        SEG_RISE = 2'd0,
        SEG_HIGH = 2'd1,
        SEG_FALL = 2'd2,
        SEG_LOW  = 2'd3
    } seg_t;

    // per-stage load enables for a channel slice
    typedef struct packed {
        logic en4;
        logic en5;
        logic en6;
    } stg_en_t;

    // base palette, {r, g, b}; unused classes are black
    function automatic logic [23:0] pal_rgb(input logic [3:0] cls);
        logic [23:0] c;
        case (cls)
            4'd0:    c = 24'hCCCCCC;
            4'd1:    c = 24'h6A9955;
            4'd2:    c = 24'hAAAAAA;
            4'd3:    c = 24'hFF7411;
            4'd4:    c = 24'h4EC9B0;
            4'd5:    c = 24'hDCDCAA;
            4'd6:    c = 24'hF6CC86;
            4'd7:    c = 24'h569CD6;
            4'd8:    c = 24'hD8A0DF;
            4'd9:    c = 24'hB5CEA8;
            4'd10:   c = 24'hCE9178;
            4'd11:   c = 24'hAAAAAA;
            4'd12:   c = 24'hFF4747;
            default: c = 24'h000000;
        endcase
        return c;
    endfunction

    // shift-subtract division, used only to build constant tables
    function automatic logic [63:0] ldiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[62:0], n[i]};
            if (r >= d) begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // hue and saturation of one palette class, {h, s}
    function automatic logic [2*VW-1:0] hs_of(input logic [3:0] cls);
        logic [23:0] c;
        logic [63:0] one, r, g, b, mx, mn, d, l, den, s, h6, h;
        c   = pal_rgb(cls);
        one = 64'd1 << FRAC_BITS;
        r   = ldiv({56'd0, c[23:16]} << FRAC_BITS, 64'd255);
        g   = ldiv({56'd0, c[15:8]} << FRAC_BITS, 64'd255);
        b   = ldiv({56'd0, c[7:0]} << FRAC_BITS, 64'd255);
        mx  = (r > g) ? r : g;
        mn  = (r < g) ? r : g;
        if (b > mx) mx = b;
        if (b < mn) mn = b;
        s = '0;
        h = '0;
        if (mx != mn) begin
            d   = mx - mn;
            l   = (mx + mn) >> 1;
            den = (l > 64'(HALF)) ? (2 * one - mx - mn) : (mx + mn);
            if ((l > 64'(HALF)) && (mx + mn > 2 * one))
                den = '0;
            s = (den != 0) ? ldiv(d * one, den) : 64'd0;
            if (mx == r) begin
                if (g >= b)
                    h6 = ldiv((g - b) * one, d);
                else
                    h6 = 6 * one - ldiv((b - g) * one, d);
            end else if (mx == g) begin
                h6 = (b >= r) ? 2 * one + ldiv((b - r) * one, d)
                              : 2 * one - ldiv((r - b) * one, d);
            end else begin
                h6 = (r >= g) ? 4 * one + ldiv((r - g) * one, d)
                              : 4 * one - ldiv((g - r) * one, d);
            end
            h = ldiv(h6, 64'd6);
        end
        return {fx_t'(h), fx_t'(s)};
    endfunction

    function automatic fx_tab_t build_h();
        fx_tab_t t;
        logic [2*VW-1:0] hs;
        for (int i = 0; i < 16; i++) begin
            hs   = hs_of(4'(i));
            t[i] = hs[2*VW-1:VW];
        end
        return t;
    endfunction

    function automatic fx_tab_t build_s();
        fx_tab_t t;
        logic [2*VW-1:0] hs;
        for (int i = 0; i < 16; i++) begin
            hs   = hs_of(4'(i));
            t[i] = hs[VW-1:0];
        end
        return t;
    endfunction

    localparam fx_tab_t H_TAB = build_h();
    localparam fx_tab_t S_TAB = build_s();

endpackage

// ----- design/phlr_chan.sv -----
`timescale 1ns / 1ps

// One output channel: hue segment product, segment select, byte conversion
module phlr_chan
    import phlr_pkg::*;
(
    input  logic       clk,
    input  stg_en_t    en,
    input  fx_t        p,
    input  fx_t        q,
    input  fx_t        qp,
    input  fx_t        t,
    input  fx_t        lum,
    input  logic       grey,
    input  logic       direct,
    input  logic [7:0] raw,
    output logic [7:0] chan
);

    logic [VW+2:0]   t6;
    logic [VW+2:0]   f6;
    fx_t             m;
    seg_t            kind;

    seg_t            kind_reg;
    logic [2*VW-1:0] prod_reg;
    fx_t             p4_reg, q4_reg, lum4_reg;
    logic            grey4_reg, direct4_reg;
    logic [7:0]      raw4_reg;

    fx_t             c_next;
    fx_t             c_reg;
    logic            direct5_reg;
    logic [7:0]      raw5_reg;

    logic [VW+9:0]   c255;
    logic [VW+9:0]   bsh;
    logic [7:0]      byte_next;
    logic [7:0]      chan_reg;

    // segment pick and multiplier operand
    always_comb
    begin
        t6 = {t, 3'b000} - {2'b00, t, 1'b0};
        f6 = {TWO3 - t, 3'b000} - {2'b00, TWO3 - t, 1'b0};
        if (t < SIXTH)
        begin
            kind = SEG_RISE;
            m    = fx_t'(t6);
        end
        else if (t < HALF)
        begin
            kind = SEG_HIGH;
            m    = '0;
        end
        else if (t < TWO3)
        begin
            kind = SEG_FALL;
            m    = fx_t'(f6);
        end
        else
        begin
            kind = SEG_LOW;
            m    = '0;
        end
    end

    // stage 4: product
    always_ff @(posedge clk)
    begin
        if (en.en4)
        begin
            kind_reg    <= kind;
            prod_reg    <= qp * m;
            p4_reg      <= p;
            q4_reg      <= q;
            lum4_reg    <= lum;
            grey4_reg   <= grey;
            direct4_reg <= direct;
            raw4_reg    <= raw;
        end
    end

    // stage 5: channel fraction
    always_comb
    begin
        case (kind_reg)
            SEG_RISE: c_next = p4_reg + fx_t'(prod_reg >> FRAC_BITS);
            SEG_FALL: c_next = p4_reg + fx_t'(prod_reg >> FRAC_BITS);
            SEG_HIGH: c_next = q4_reg;
            SEG_LOW:  c_next = p4_reg;
            default:  c_next = p4_reg;
        endcase
        if (grey4_reg)
            c_next = lum4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en.en5)
        begin
            c_reg       <= c_next;
            direct5_reg <= direct4_reg;
            raw5_reg    <= raw4_reg;
        end
    end

    // stage 6: back to 8 bits, truncated and saturated, or the raw palette byte when direct
    always_comb
    begin
        c255 = {2'b00, c_reg, 8'd0} - {10'd0, c_reg};
        bsh  = c255 >> FRAC_BITS;
        if (direct5_reg)
            byte_next = raw5_reg;
        else if (bsh > (VW+10)'(255))
            byte_next = 8'hFF;
        else
            byte_next = bsh[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (en.en6)
            chan_reg <= byte_next;
    end

    assign chan = chan_reg;

endmodule

// ----- design/palette_hsl_lightness_recolor_top.sv -----
`timescale 1ns / 1ps
// Palette recolor with HSL lightness replacement.
// Each word is registered in every pipeline stage, from palette lookup to byte conversion.
// Throughput: one word per cycle while m_tready is high; each stage holds independently under backpressure.
// Reset (rst_n low, async): pipeline empty, lightness_target = 0 (pass-through).
module palette_hsl_lightness_recolor_top
    import phlr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,       // lightness_target
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,        // [3:0] color_class
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata         // [7:0] red, [15:8] green, [23:16] blue
);

    logic [7:0]  lt_reg;
    logic [6:1]  v_reg;
    logic [7:1]  en;
    stg_en_t     cen;

    logic [3:0]  cls;
    logic [15:0] lb;
    logic [16:0] lz;
    fx_t         lum;

    fx_t         h1_reg, s1_reg, l1_reg;
    logic        grey1_reg, direct1_reg;
    logic [23:0] rgb1_reg;

    logic [2*VW-1:0] ls2_reg;
    fx_t         s2_reg, l2_reg, tr2_reg, tg2_reg, tb2_reg;
    logic        grey2_reg, direct2_reg;
    logic [23:0] rgb2_reg;
    fx_t         tr_next, tb_next;

    fx_t         ls, q_next, p_next, qp_next;
    logic [VW:0] l2x;
    fx_t         q3_reg, p3_reg, qp3_reg, l3_reg, tr3_reg, tg3_reg, tb3_reg;
    logic        grey3_reg, direct3_reg;
    logic [23:0] rgb3_reg;

    // config register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lt_reg <= '0;
        else if (cfg_valid)
            lt_reg <= cfg_data;
    end

    // stage enables: a stage loads when empty or when its successor moves
    always_comb
    begin
        en[7] = m_tready;
        for (int k = 6; k >= 1; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign s_tready = en[1];
    assign m_tvalid = v_reg[6];
    assign cen      = '{en4: en[4], en5: en[5], en6: en[6]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[1]) v_reg[1] <= s_tvalid;
            for (int k = 2; k <= 6; k++)
                if (en[k]) v_reg[k] <= v_reg[k-1];
        end
    end

    // stage 1: palette lookup and target lightness
    assign cls = s_tdata[3:0];
    assign lb  = lt_reg * 8'(DIV_B);
    assign lz  = ({1'b0, lb} + {9'd0, lb[15:8]} + 17'd1) >> 8;
    assign lum = fx_t'(lt_reg * fx_t'(DIV_A)) + fx_t'(lz);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            h1_reg      <= H_TAB[cls];
            s1_reg      <= S_TAB[cls];
            l1_reg      <= lum;
            grey1_reg   <= (S_TAB[cls] == '0);
            direct1_reg <= (lt_reg == 8'd0);
            rgb1_reg    <= pal_rgb(cls);
        end
    end

    // stage 2: L*s and shifted hues
    always_comb
    begin
        tr_next = h1_reg + THIRD;
        if (tr_next > ONE)
            tr_next = tr_next - ONE;
        tb_next = (h1_reg >= THIRD) ? h1_reg - THIRD : h1_reg + ONE - THIRD;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            ls2_reg     <= l1_reg * s1_reg;
            s2_reg      <= s1_reg;
            l2_reg      <= l1_reg;
            tr2_reg     <= tr_next;
            tg2_reg     <= h1_reg;
            tb2_reg     <= tb_next;
            grey2_reg   <= grey1_reg;
            direct2_reg <= direct1_reg;
            rgb2_reg    <= rgb1_reg;
        end
    end

    // stage 3: q, p and q - p
    always_comb
    begin
        ls      = fx_t'(ls2_reg >> FRAC_BITS);
        q_next  = (l2_reg < HALF) ? l2_reg + ls : l2_reg + s2_reg - ls;
        l2x     = {l2_reg, 1'b0};
        p_next  = (l2x >= {1'b0, q_next}) ? fx_t'(l2x - {1'b0, q_next}) : '0;
        qp_next = (q_next >= p_next) ? q_next - p_next : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            q3_reg      <= q_next;
            p3_reg      <= p_next;
            qp3_reg     <= qp_next;
            l3_reg      <= l2_reg;
            tr3_reg     <= tr2_reg;
            tg3_reg     <= tg2_reg;
            tb3_reg     <= tb2_reg;
            grey3_reg   <= grey2_reg;
            direct3_reg <= direct2_reg;
            rgb3_reg    <= rgb2_reg;
        end
    end

    // stages 4 to 6 per channel
    phlr_chan u_red (
        .clk    (clk),
        .en     (cen),
        .p      (p3_reg),
        .q      (q3_reg),
        .qp     (qp3_reg),
        .t      (tr3_reg),
        .lum    (l3_reg),
        .grey   (grey3_reg),
        .direct (direct3_reg),
        .raw    (rgb3_reg[23:16]),
        .chan   (m_tdata[7:0])
    );

    phlr_chan u_green (
        .clk    (clk),
        .en     (cen),
        .p      (p3_reg),
        .q      (q3_reg),
        .qp     (qp3_reg),
        .t      (tg3_reg),
        .lum    (l3_reg),
        .grey   (grey3_reg),
        .direct (direct3_reg),
        .raw    (rgb3_reg[15:8]),
        .chan   (m_tdata[15:8])
    );

    phlr_chan u_blue (
        .clk    (clk),
        .en     (cen),
        .p      (p3_reg),
        .q      (q3_reg),
        .qp     (qp3_reg),
        .t      (tb3_reg),
        .lum    (l3_reg),
        .grey   (grey3_reg),
        .direct (direct3_reg),
        .raw    (rgb3_reg[7:0]),
        .chan   (m_tdata[23:16])
    );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import phlr_pkg::*;

    localparam int FB        = 16;
    localparam int LATENCY   = 6;
    localparam int WDOG_MAX  = 5000;
    localparam int N_RANDOM  = 1000;

    typedef logic [63:0] u64_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // palette scoreboard: predicts recolored pixels and checks the output words
    class recolor_sb;
        rgb_t       pending[$];
        logic [7:0] lightness;
        int         errors;

        function new();
            lightness = 8'd0;
            errors    = 0;
        endfunction

        function u64_t frac_of(input logic [7:0] v);
            return (u64_t'(v) << FB) / 255;
        endfunction

        function u64_t seg_of(input u64_t base, input u64_t a, input u64_t b, input u64_t d);
            if (a >= b)
                return base * (u64_t'(1) << FB) + ((a - b) << FB) / d;
            return base * (u64_t'(1) << FB) - ((b - a) << FB) / d;
        endfunction

        function u64_t chan_of(input u64_t p, input u64_t q, input u64_t t);
            u64_t one;
            u64_t qp;
            one = u64_t'(1) << FB;
            qp  = (q >= p) ? q - p : 0;
            if (t < one / 6)
                return p + ((qp * 6 * t) >> FB);
            if (t < one / 2)
                return q;
            if (t < (2 * one) / 3)
                return p + ((qp * 6 * ((2 * one) / 3 - t)) >> FB);
            return p;
        endfunction

        function logic [7:0] byte_of(input u64_t c);
            u64_t v;
            v = (c * 255) >> FB;
            return (v > 255) ? 8'd255 : v[7:0];
        endfunction

        function rgb_t recolor(input logic [3:0] cls);
            logic [7:0] base [13][3];
            u64_t one, r, g, b, mx, mn, lt, s, h, d, l, den, h6;
            u64_t q, p, tr, tb;
            rgb_t o;
            base = '{'{8'hCC, 8'hCC, 8'hCC}, '{8'h6A, 8'h99, 8'h55}, '{8'hAA, 8'hAA, 8'hAA},
                     '{8'hFF, 8'h74, 8'h11}, '{8'h4E, 8'hC9, 8'hB0}, '{8'hDC, 8'hDC, 8'hAA},
                     '{8'hF6, 8'hCC, 8'h86}, '{8'h56, 8'h9C, 8'hD6}, '{8'hD8, 8'hA0, 8'hDF},
                     '{8'hB5, 8'hCE, 8'hA8}, '{8'hCE, 8'h91, 8'h78}, '{8'hAA, 8'hAA, 8'hAA},
                     '{8'hFF, 8'h47, 8'h47}};
            o = '0;
            if (cls < 13)
                o = {base[cls][0], base[cls][1], base[cls][2]};
            if (lightness == 0)
                return o;
            one = u64_t'(1) << FB;
            r   = frac_of(o.red);
            g   = frac_of(o.green);
            b   = frac_of(o.blue);
            mx  = (r > g) ? r : g;
            mn  = (r < g) ? r : g;
            if (b > mx) mx = b;
            if (b < mn) mn = b;
            lt = frac_of(lightness);
            s  = 0;
            h  = 0;
            if (mx != mn) begin
                d   = mx - mn;
                l   = (mx + mn) / 2;
                den = (l > one / 2) ? (2 * one - mx - mn) : (mx + mn);
                if ((l > one / 2) && (mx + mn > 2 * one))
                    den = 0;
                s = (den != 0) ? (d << FB) / den : 0;
                if (mx == r)
                    h6 = (g >= b) ? seg_of(0, g, b, d) : seg_of(6, g, b, d);
                else if (mx == g)
                    h6 = seg_of(2, b, r, d);
                else
                    h6 = seg_of(4, r, g, d);
                h = h6 / 6;
            end
            if (s == 0) begin
                o.red   = byte_of(lt);
                o.green = o.red;
                o.blue  = o.red;
                return o;
            end
            if (lt < one / 2)
                q = (lt * (one + s)) >> FB;
            else
                q = lt + s - ((lt * s) >> FB);
            p  = (2 * lt >= q) ? 2 * lt - q : 0;
            tr = h + one / 3;
            if (tr > one)
                tr -= one;
            tb = (h >= one / 3) ? h - one / 3 : h + one - one / 3;
            o.red   = byte_of(chan_of(p, q, tr));
            o.green = byte_of(chan_of(p, q, h));
            o.blue  = byte_of(chan_of(p, q, tb));
            return o;
        endfunction

        function void note_input(input logic [3:0] cls);
            pending.push_back(recolor(cls));
        endfunction

        function void check_output(input logic [23:0] word);
            rgb_t exp_px;
            if (pending.size() == 0) begin
                report_err($sformatf("unexpected word %h", word));
                return;
            end
            exp_px = pending.pop_front();
            if (word[7:0] !== exp_px.red)
                report_err($sformatf("red %h, want %h", word[7:0], exp_px.red));
            if (word[15:8] !== exp_px.green)
                report_err($sformatf("green %h, want %h", word[15:8], exp_px.green));
            if (word[23:16] !== exp_px.blue)
                report_err($sformatf("blue %h, want %h", word[23:16], exp_px.blue));
        endfunction

        function void report_err(input string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    recolor_sb sb;
    int        idle_cycles = 0;
    bit        sink_hold;

    palette_hsl_lightness_recolor_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // random gap: mostly short, sometimes long
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50)
            return 0;
        if (k < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output side: sample at rising edge, change ready at falling edge
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_output(m_tdata);
    end

    initial begin
        int n;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (sink_hold) begin
                m_tready <= 1'b1;
            end else begin
                n = gap_len();
                if (n == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat (n - 1) @(negedge clk);
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("[palette_hsl_lightness_recolor_top] ERROR");
            $finish;
        end
    end

    task automatic send_class(input logic [3:0] cls, input bit gaps);
        int n;
        n = gaps ? gap_len() : 0;
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, cls};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(cls);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    task automatic write_lightness(input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.lightness = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [7:0] settings [6];
        int k;
        sb          = new();
        sink_hold   = 1'b0;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 8'd0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'd0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // pass-through after reset: every class back to back, invalid ones too
        for (int c = 0; c < 16; c++)
            send_class(4'(c), 1'b0);
        drain();

        // extremes and mid values of the lightness register
        settings = '{8'd255, 8'd1, 8'd128, 8'd127, 8'd0, 8'd200};
        foreach (settings[i]) begin
            write_lightness(settings[i]);
            for (int c = 0; c < 16; c += 3)
                send_class(4'(c), 1'b0);
            send_class(4'd15, 1'b0);
            drain();
        end

        // random phases, fresh lightness each time
        for (int ph = 0; ph < 8; ph++) begin
            write_lightness((ph == 3) ? 8'd0 : 8'($urandom_range(0, 255)));
            sink_hold = (ph == 5);
            for (int i = 0; i < N_RANDOM / 8; i++) begin
                k = $urandom_range(0, 99);
                send_class(4'($urandom_range(0, 15)), (k < 70));
                // hold the source until the pipeline is empty
                if (i == 60)
                begin
                    s_tvalid <= 1'b0;
                    while (sb.pending.size() != 0)
                        @(negedge clk);
                end
            end
            drain();
        end

        if (sb.errors == 0)
            $display("[palette_hsl_lightness_recolor_top] OK");
        else
            $display("[palette_hsl_lightness_recolor_top] ERROR");
        $finish;
    end

endmodule
